// ===== src/uer_pkg.sv =====
// Shared types and constants for the ultrasonic echo ranger.
package uer_pkg;

    localparam int CH_W          = 3;
    localparam int DIST_W        = 16;
    localparam int NUM_DEV_W     = 4;
    localparam int PULSE_W       = 8;
    localparam int PRESCALE_W    = 6;
    localparam int TICKS_PER_MM  = 58;
    localparam int DEF_MAX_CHANNELS = 8;
    localparam int DEF_PULSE_TICKS  = 200;

    localparam logic [NUM_DEV_W-1:0] NUM_DEV_RESET = 4'd1;
    localparam logic [DIST_W-1:0]    DIST_MAX      = 16'hFFFF;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PULSE   = 2'd1,
        PH_WAIT    = 2'd2,
        PH_MEASURE = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_START = 2'd1,
        ACT_READ  = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef enum logic {
        REG_NUM_DEVICES  = 1'b0,
        REG_AUTO_ADVANCE = 1'b1
    } reg_index_t;

    // Distance store access from the control logic
    typedef struct packed {
        logic              wr_en;
        logic [CH_W-1:0]   wr_ch;
        logic [DIST_W-1:0] wr_data;
        logic              clr;
        logic [CH_W-1:0]   rd_ch;
    } store_req_t;

endpackage

// ===== src/uer_store.sv =====
// Per-channel distance store with single write, clear-all and one read port.
module uer_store #(
    parameter int MAX_CHANNELS = uer_pkg::DEF_MAX_CHANNELS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  uer_pkg::store_req_t       req,
    output logic [uer_pkg::DIST_W-1:0] rd_data
);
    import uer_pkg::*;

    logic [DIST_W-1:0] dist_reg [MAX_CHANNELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                dist_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                if (req.clr)
                begin
                    dist_reg[i] <= '0;
                end
                else if (req.wr_en && (32'(req.wr_ch) == i))
                begin
                    dist_reg[i] <= req.wr_data;
                end
            end
        end
    end

    // channels beyond the store read as zero
    always_comb
    begin
        rd_data = '0;
        for (int i = 0; i < MAX_CHANNELS; i++)
        begin
            if (32'(req.rd_ch) == i)
            begin
                rd_data = dist_reg[i];
            end
        end
    end

endmodule

// ===== src/ultrasonic_echo_ranger.sv =====
// Top level of the multi-channel ultrasonic ranger controller.
// Ultrasonic ranger controller: each input transaction is a tick (a time sample with the echo
// level), a start, a read or a clear-all. One transaction is accepted per clock cycle unless the
// output stalls, and each yields exactly one result transaction in the next cycle; all work for
// an item is done in the logic between the input handshake and the single output register, so
// the rate is one item per cycle whenever the output side takes results. A start fires a trigger
// pulse of PULSE_TICKS ticks, then the echo high time is prescaled by 58 ticks per millimeter,
// saturating at 65535, and stored per channel. Configuration writes are always ready.
module ultrasonic_echo_ranger #(
    parameter int MAX_CHANNELS = uer_pkg::DEF_MAX_CHANNELS,
    parameter int PULSE_TICKS  = uer_pkg::DEF_PULSE_TICKS
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [2:0] device, [3] echo_level, [7:4] zero
    input  logic [1:0]  s_tuser,   // [1:0] action
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [0] trigger_high, [3:1] trigger_channel, [4] busy_res,
                                   // [5] done_res, [8:6] done_channel, [24:9] distance_mm,
                                   // [31:25] zero
);
    import uer_pkg::*;

    localparam int EFF_W = 5;

    logic [NUM_DEV_W-1:0]  num_devices_reg;
    logic                  auto_advance_reg;

    phase_t                phase_reg, phase_next;
    logic [CH_W-1:0]       chan_reg, chan_next;
    logic [PULSE_W-1:0]    pulse_reg, pulse_next;
    logic [PRESCALE_W-1:0] prescale_reg, prescale_next;
    logic [DIST_W-1:0]     echo_cnt_reg, echo_cnt_next;

    logic                  out_valid_reg;
    logic [31:0]           out_data_reg;

    action_t               action;
    logic [CH_W-1:0]       device;
    logic                  echo_level;
    logic                  accept;
    logic [EFF_W-1:0]      eff_devices;

    store_req_t            store_req;
    logic [DIST_W-1:0]     store_rd;

    logic                  trig;
    logic                  done;
    logic [CH_W-1:0]       done_ch;
    logic [DIST_W-1:0]     dist_mm;
    logic [PULSE_W-1:0]    pulse_inc;
    logic [PRESCALE_W-1:0] prescale_inc;
    logic [DIST_W-1:0]     echo_upd;

    assign action     = action_t'(s_tuser);
    assign device     = s_tdata[2:0];
    assign echo_level = s_tdata[3];

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign eff_devices = (EFF_W'(num_devices_reg) > EFF_W'(MAX_CHANNELS))
                       ? EFF_W'(MAX_CHANNELS) : EFF_W'(num_devices_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_devices_reg  <= NUM_DEV_RESET;
            auto_advance_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_NUM_DEVICES:  num_devices_reg  <= cfg_data;
                REG_AUTO_ADVANCE: auto_advance_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        pulse_inc    = pulse_reg + PULSE_W'(1);
        prescale_inc = prescale_reg + PRESCALE_W'(1);
        echo_upd     = echo_cnt_reg;
        if (prescale_inc >= PRESCALE_W'(TICKS_PER_MM) && echo_cnt_reg != DIST_MAX)
        begin
            echo_upd = echo_cnt_reg + DIST_W'(1);
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        chan_next     = chan_reg;
        pulse_next    = pulse_reg;
        prescale_next = prescale_reg;
        echo_cnt_next = echo_cnt_reg;
        trig          = 1'b0;
        done          = 1'b0;
        done_ch       = '0;
        dist_mm       = '0;
        store_req.wr_en   = 1'b0;
        store_req.wr_ch   = chan_reg;
        store_req.wr_data = echo_upd;
        store_req.clr     = 1'b0;
        store_req.rd_ch   = device;

        if (action == ACT_TICK)
        begin
            unique case (phase_reg)
                PH_PULSE:
                begin
                    trig       = 1'b1;
                    pulse_next = pulse_inc;
                    if (pulse_inc >= PULSE_W'(PULSE_TICKS))
                    begin
                        phase_next = PH_WAIT;
                    end
                end
                PH_WAIT:
                begin
                    if (echo_level)
                    begin
                        phase_next    = PH_MEASURE;
                        prescale_next = '0;
                        echo_cnt_next = '0;
                    end
                end
                PH_MEASURE:
                begin
                    prescale_next = (prescale_inc >= PRESCALE_W'(TICKS_PER_MM))
                                  ? '0 : prescale_inc;
                    echo_cnt_next = echo_upd;
                    if (!echo_level)
                    begin
                        done            = 1'b1;
                        done_ch         = chan_reg;
                        dist_mm         = echo_upd;
                        store_req.wr_en = accept;
                        phase_next      = PH_IDLE;
                        // auto advance to the next channel in use
                        if (auto_advance_reg
                            && (EFF_W'(chan_reg) + EFF_W'(1) < eff_devices))
                        begin
                            chan_next     = chan_reg + CH_W'(1);
                            phase_next    = PH_PULSE;
                            pulse_next    = '0;
                            prescale_next = '0;
                            echo_cnt_next = '0;
                        end
                    end
                end
                default: ;
            endcase
        end
        else
        begin
            case (action)
                ACT_START:
                begin
                    if (EFF_W'(device) < eff_devices)
                    begin
                        chan_next     = device;
                        phase_next    = PH_PULSE;
                        pulse_next    = '0;
                        prescale_next = '0;
                        echo_cnt_next = '0;
                    end
                end
                ACT_READ:  dist_mm = store_rd;
                default:   store_req.clr = accept;
            endcase
            trig = (phase_next == PH_PULSE);
        end
    end

    uer_store #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (store_req),
        .rd_data (store_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            chan_reg     <= '0;
            pulse_reg    <= '0;
            prescale_reg <= '0;
            echo_cnt_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            chan_reg     <= chan_next;
            pulse_reg    <= pulse_next;
            prescale_reg <= prescale_next;
            echo_cnt_reg <= echo_cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= {7'd0, dist_mm, done_ch, done, (phase_next != PH_IDLE),
                             chan_next, trig};
        end
    end

endmodule

// ===== test/ranger_checker.sv =====
`timescale 1ns / 1ps
// Checker for the ultrasonic echo ranger: tracks every channel, predicts each reading, compares.
module ranger_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [2:0] device, [3] echo_level, [7:4] zero
    input  logic [1:0]  s_tuser,   // [1:0] action
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [0] trigger_high, [3:1] trigger_channel, [4] busy_res,
                                   // [5] done_res, [8:6] done_channel, [24:9] distance_mm,
                                   // [31:25] zero
    output int          mismatches,
    output int          readings_due
);
    import uer_pkg::*;

    localparam int MAX_CH = DEF_MAX_CHANNELS;

    // Field order matches the result bus, trigger_high in bit 0
    typedef struct packed {
        logic [DIST_W-1:0] dist_mm;
        logic [CH_W-1:0]   done_ch;
        logic              done;
        logic              busy;
        logic [CH_W-1:0]   trig_ch;
        logic              trig;
    } ranging_t;

    ranging_t pending_readings[$];
    ranging_t want;
    ranging_t got;
    ranging_t calc;
    int       readings_seen;

    // Shadow of the ranger
    logic [NUM_DEV_W-1:0]  num_dev;
    logic                  auto_adv;
    phase_t                ph;
    logic [CH_W-1:0]       act_ch;
    logic [PULSE_W-1:0]    pulse_cnt;
    logic [PRESCALE_W-1:0] pre_cnt;
    logic [DIST_W-1:0]     mm_cnt;
    logic [DIST_W-1:0]     dist_mem[MAX_CH];

    task automatic flag_mismatch(string what, longint got_v, longint want_v);
        $display("%0t ns: reading %0d, %s: got %0d, expected %0d",
                 $time, readings_seen, what, got_v, want_v);
        mismatches++;
    endtask

    task automatic arm_channel(logic [CH_W-1:0] ch);
        act_ch    = ch;
        ph        = PH_PULSE;
        pulse_cnt = '0;
        pre_cnt   = '0;
        mm_cnt    = '0;
    endtask

    task automatic predict_ranging(action_t act, logic [CH_W-1:0] dev, logic echo,
                                   output ranging_t r);
        int in_use;
        in_use = (int'(num_dev) > MAX_CH) ? MAX_CH : int'(num_dev);
        r = '0;
        case (act)
            ACT_TICK:
            begin
                case (ph)
                    PH_PULSE:
                    begin
                        r.trig    = 1'b1;
                        pulse_cnt = pulse_cnt + 1'b1;
                        if (pulse_cnt >= DEF_PULSE_TICKS)
                            ph = PH_WAIT;
                    end
                    PH_WAIT:
                    begin
                        // a low level before the rising edge keeps us waiting
                        if (echo)
                        begin
                            ph      = PH_MEASURE;
                            pre_cnt = '0;
                            mm_cnt  = '0;
                        end
                    end
                    PH_MEASURE:
                    begin
                        pre_cnt = pre_cnt + 1'b1;
                        if (pre_cnt >= TICKS_PER_MM)
                        begin
                            pre_cnt = '0;
                            if (mm_cnt != DIST_MAX)
                                mm_cnt = mm_cnt + 1'b1;
                        end
                        if (!echo)
                        begin
                            r.done    = 1'b1;
                            r.done_ch = act_ch;
                            r.dist_mm = mm_cnt;
                            if (int'(act_ch) < MAX_CH)
                                dist_mem[act_ch] = mm_cnt;
                            ph = PH_IDLE;
                            if (auto_adv && int'(act_ch) + 1 < in_use)
                                arm_channel(act_ch + 1'b1);
                        end
                    end
                    default: ;
                endcase
            end
            ACT_START:
            begin
                if (int'(dev) < in_use)
                    arm_channel(dev);
            end
            ACT_READ:
                r.dist_mm = (int'(dev) < MAX_CH) ? dist_mem[dev] : '0;
            default:
            begin
                for (int i = 0; i < MAX_CH; i++)
                    dist_mem[i] = '0;
            end
        endcase
        if (act != ACT_TICK)
            r.trig = (ph == PH_PULSE);
        r.trig_ch = act_ch;
        r.busy    = (ph != PH_IDLE);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dev   = NUM_DEV_RESET;
            auto_adv  = 1'b0;
            ph        = PH_IDLE;
            act_ch    = '0;
            pulse_cnt = '0;
            pre_cnt   = '0;
            mm_cnt    = '0;
            for (int i = 0; i < MAX_CH; i++)
                dist_mem[i] = '0;
            pending_readings.delete();
            readings_seen = 0;
            mismatches    = 0;
        end
        else
        begin
            // results first: they belong to items accepted at earlier edges
            if (m_tvalid && m_tready)
            begin
                readings_seen++;
                if (pending_readings.size() == 0)
                    flag_mismatch("unexpected transaction", m_tdata, 0);
                else
                begin
                    want = pending_readings.pop_front();
                    got  = m_tdata[24:0];
                    if (got.trig != want.trig)
                        flag_mismatch("trigger_high", got.trig, want.trig);
                    if (got.trig_ch != want.trig_ch)
                        flag_mismatch("trigger_channel", got.trig_ch, want.trig_ch);
                    if (got.busy != want.busy)
                        flag_mismatch("busy_res", got.busy, want.busy);
                    if (got.done != want.done)
                        flag_mismatch("done_res", got.done, want.done);
                    if (got.done_ch != want.done_ch)
                        flag_mismatch("done_channel", got.done_ch, want.done_ch);
                    if (got.dist_mm != want.dist_mm)
                        flag_mismatch("distance_mm", got.dist_mm, want.dist_mm);
                    if (m_tdata[31:25] != '0)
                        flag_mismatch("padding", m_tdata[31:25], 0);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (reg_index_t'(cfg_index) == REG_NUM_DEVICES)
                    num_dev = cfg_data;
                else
                    auto_adv = cfg_data[0];
            end
            if (s_tvalid && s_tready)
            begin
                predict_ranging(action_t'(s_tuser), s_tdata[2:0], s_tdata[3], calc);
                pending_readings = {pending_readings, calc};
            end
        end
        readings_due = pending_readings.size();
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Top of the ranger testbench: clock, reset, stimulus, output flow control and verdict.
module testbench;
    import uer_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;
    localparam int ECHO_LOW    = 0;
    localparam int ECHO_HIGH   = 1;
    localparam int ECHO_ANY    = 2;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [3:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [2:0] device, [3] echo_level, [7:4] zero
    logic [1:0]  s_tuser;   // [1:0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [0] trigger_high, [3:1] trigger_channel, [4] busy_res,
                            // [5] done_res, [8:6] done_channel, [24:9] distance_mm

    int mismatches;
    int readings_due;
    int sent_count     = 0;
    int src_gap_pct    = 8;
    int sink_stall_pct = 61;
    int dev_limit      = 1;
    bit auto_on        = 1'b0;
    bit held_off       = 1'b0;
    int quiet_cycles   = 0;

    ultrasonic_echo_ranger uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    ranger_checker ranger_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .mismatches   (mismatches),
        .readings_due (readings_due)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // No transaction for too long means the block hung
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: random stalls plus one long hold-off to back up the input
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_off && sent_count >= 900)
            begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    task automatic push_item(action_t act, logic [2:0] dev, logic echo);
        while ($urandom_range(0, 99) < src_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, echo, dev};
        s_tuser  <= act;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        sent_count++;
    endtask

    task automatic tick_run(int n, int mode, bit sprinkle);
        repeat (n)
        begin
            // the odd read or clear in the middle of a measurement
            if (sprinkle && $urandom_range(0, 99) < 4)
                push_item(($urandom_range(0, 3) == 0) ? ACT_CLEAR : ACT_READ,
                          3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            push_item(ACT_TICK, 3'($urandom_range(0, 7)),
                      (mode == ECHO_ANY) ? 1'($urandom_range(0, 1)) : (mode == ECHO_HIGH));
        end
    endtask

    // Trigger pulse with noise on echo, low wait, echo high, then the falling edge
    task automatic echo_cycle(int wait_ticks, int high_ticks);
        tick_run(DEF_PULSE_TICKS, ECHO_ANY, 1'b0);
        tick_run(wait_ticks, ECHO_LOW, 1'b1);
        tick_run(high_ticks + 1, ECHO_HIGH, 1'b1);
        tick_run(1, ECHO_LOW, 1'b0);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (readings_due != 0) @(negedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [3:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_config(logic [3:0] n_dev, logic adv);
        drain_results();
        write_reg(REG_NUM_DEVICES, n_dev);
        write_reg(REG_AUTO_ADVANCE, {3'b000, adv});
        cfg_valid <= 1'b0;
        dev_limit = (n_dev > DEF_MAX_CHANNELS) ? DEF_MAX_CHANNELS : n_dev;
        auto_on   = adv;
    endtask

    function automatic logic [2:0] pick_device();
        if (dev_limit > 0 && $urandom_range(0, 99) < 85)
            return 3'($urandom_range(0, dev_limit - 1));
        return 3'($urandom_range(0, 7));
    endfunction

    task automatic random_phase(int n);
        int first;
        int roll;
        first = sent_count;
        while (sent_count - first < n)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 75)
            begin
                // with auto advance a chained channel may already be pulsing
                if (!(auto_on && $urandom_range(0, 3) == 0))
                    push_item(ACT_START, pick_device(), 1'($urandom_range(0, 1)));
                echo_cycle($urandom_range(0, 4), ($urandom_range(0, 9) == 0) ?
                           $urandom_range(170, 300) : $urandom_range(0, 130));
            end
            else if (roll < 90)
            begin
                repeat ($urandom_range(1, 12))
                    push_item(action_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                              1'($urandom_range(0, 1)));
            end
            else
            begin
                // measurement cut short by the next start
                push_item(ACT_START, pick_device(), 1'b0);
                tick_run($urandom_range(1, 199), ECHO_ANY, 1'b0);
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = ACT_TICK;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset configuration: one channel, no auto advance
        push_item(ACT_READ, 3'd7, 1'b0);
        push_item(ACT_CLEAR, 3'd0, 1'b1);
        push_item(ACT_START, 3'd1, 1'b0);   // beyond num_devices
        push_item(ACT_TICK, 3'd0, 1'b1);    // idle tick
        push_item(ACT_START, 3'd0, 1'b1);
        echo_cycle(2, 115);
        push_item(ACT_READ, 3'd0, 1'b0);
        push_item(ACT_CLEAR, 3'd5, 1'b0);
        push_item(ACT_READ, 3'd0, 1'b1);

        // zero channels: every start dropped
        set_config(4'd0, 1'b0);
        push_item(ACT_START, 3'd0, 1'b0);
        push_item(ACT_START, 3'd7, 1'b1);

        // above the channel count acts as the maximum; chain 6 -> 7 -> idle
        set_config(4'd15, 1'b1);
        push_item(ACT_START, 3'd6, 1'b0);
        echo_cycle(0, 0);
        echo_cycle(1, 57);
        push_item(ACT_TICK, 3'd3, 1'b1);
        push_item(ACT_START, 3'd7, 1'b0);
        tick_run(20, ECHO_ANY, 1'b0);
        push_item(ACT_START, 3'd4, 1'b0);   // restart while busy
        tick_run(210, ECHO_ANY, 1'b0);
        push_item(ACT_READ, 3'd6, 1'b0);
        push_item(ACT_READ, 3'd7, 1'b0);

        src_gap_pct    = 61;
        sink_stall_pct = 8;
        set_config(4'd8, 1'b1);
        random_phase(40);

        src_gap_pct    = 0;
        sink_stall_pct = 0;
        set_config(4'd3, 1'b0);
        random_phase(40);

        drain_results();
        repeat (16) @(negedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
src/uer_pkg.sv
src/uer_store.sv
src/ultrasonic_echo_ranger.sv
test/ranger_checker.sv
test/testbench.sv
